FILE: sv/pmfb_pkg.sv
`default_nettype none

package pmfb_pkg;

    localparam int FIELD_SPAN = 1024;
    localparam int WORD_BITS  = 32;
    localparam int PN_W       = 10;
    localparam int VA_W       = 22;
    localparam int OFS_W      = 12;
    localparam int ENT_W      = 13;
    localparam int ENT_FR_LSB = 3;

    localparam logic [2:0] ACT_IDENT = 3'd0;
    localparam logic [2:0] ACT_ALLOC = 3'd1;
    localparam logic [2:0] ACT_MAPAT = 3'd2;
    localparam logic [2:0] ACT_UNMAP = 3'd3;
    localparam logic [2:0] ACT_XLATE = 3'd4;
    localparam logic [2:0] ACT_PRES  = 3'd5;

    localparam int ENT_PRESENT = 0;

    typedef struct packed {
        logic [2:0]      action;
        logic [PN_W-1:0] page_number;
        logic [PN_W-1:0] frame_number;
        logic            user_access;
        logic [VA_W-1:0] vaddr;
    } t_in;

    typedef struct packed {
        logic            status;
        logic [PN_W-1:0] frame_out;
        logic [VA_W-1:0] phys_addr;
        logic            present;
    } t_out;

    typedef struct packed {
        logic accept;
        logic clr;
        logic rd;
        logic map_wr;
        logic scan;
        logic alloc_wr;
        logic fail;
        logic unmap_rd;
        logic unmap_wr;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic [2:0] action;
        logic       page_ok;
        logic       hit;
        logic       scan_end;
        logic       clr_done;
    } t_sts;

endpackage

`default_nettype wire

FILE: sv/page_map_with_frame_bitmap.sv
// page table with a bitmap of used physical frames
// input channel: i_in_valid / o_in_stall carry one request beat (t_in): identity map,
//   map lowest free frame, map given frame, unmap, translate, query present
// output channel: o_out_valid / i_out_stall carry one result beat (t_out) per request
// steps: translate, query and unknown actions read the entry, then load the result register;
//   map-given and identity add a write step, unmap a bitmap read and a write step
// map-lowest-free scans the frame bitmap one 32-frame word per cycle through its single
//   read port, over up to min(FRAMES/32, 32) words, then writes the found frame
// one request is in flight at a time; the next beat is taken the cycle after the result
//   is loaded into the output register, even while that result still waits to be taken
// reset: a clearing pass walks the page table one entry per cycle (bitmap cleared in the
//   same sweep); o_in_stall stays high meanwhile
// when the receiver stalls, the result beat holds and the block finishes its current
//   request, then waits before loading the next result
`default_nettype none

module page_map_with_frame_bitmap import pmfb_pkg::*; #(
    parameter int PAGES  = 1024,
    parameter int FRAMES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    pmfb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pmfb_dp #(
        .PAGES  (PAGES),
        .FRAMES (FRAMES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_in_data),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

`default_nettype wire

FILE: sv/pmfb_dp.sv
`default_nettype none

module pmfb_dp import pmfb_pkg::*; #(
    parameter int PAGES  = 1024,
    parameter int FRAMES = 1024
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cmd i_cmd,
    input  t_in  i_in_data,
    output t_sts o_sts,
    output t_out o_out_data
);

    localparam int NPAGES     = (PAGES < FIELD_SPAN) ? PAGES : FIELD_SPAN;
    localparam int NWORDS_ALL = FRAMES / WORD_BITS;
    localparam int NWORDS_MAX = FIELD_SPAN / WORD_BITS;
    localparam int NWORDS     = (NWORDS_ALL < NWORDS_MAX) ? NWORDS_ALL : NWORDS_MAX;
    localparam int MFRAMES    = (FRAMES < FIELD_SPAN) ? FRAMES : FIELD_SPAN;
    localparam int PAGE_AW    = $clog2(NPAGES);
    localparam int WORD_AW    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);

    localparam logic [PN_W:0]    NPAGES_L  = (PN_W+1)'(NPAGES);
    localparam logic [PN_W:0]    MFRAMES_L = (PN_W+1)'(MFRAMES);
    localparam logic [PN_W:0]    MARK_L    = (PN_W+1)'(NWORDS * WORD_BITS);
    localparam logic [PAGE_AW:0] NWORDS_C  = (PAGE_AW+1)'(NWORDS);
    localparam logic [WORD_AW-1:0] LAST_W  = WORD_AW'(NWORDS - 1);
    localparam logic [PAGE_AW-1:0] LAST_P  = PAGE_AW'(NPAGES - 1);

    function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (!w[b]) begin
                idx = BIT_W'(b);
            end
        end
        return idx;
    endfunction

    logic [ENT_W-1:0]     pt_mem [NPAGES];
    logic [WORD_BITS-1:0] bm_mem [NWORDS];

    t_in                  r_req;
    logic [ENT_W-1:0]     r_pt_q;
    logic [WORD_BITS-1:0] r_bm_q;
    logic [WORD_AW-1:0]   r_scan;
    logic [WORD_AW-1:0]   r_chk;
    logic                 r_chk_v;
    logic [PAGE_AW-1:0]   r_clr;
    logic [PN_W-1:0]      r_found;
    logic [WORD_BITS-1:0] r_hit_word;
    logic                 r_fail;
    logic                 r_alloc;

    logic                 page_ok;
    logic                 vp_ok;
    logic [PN_W-1:0]      vpage;
    logic [PN_W-1:0]      map_frame;
    logic                 map_ok;
    logic                 map_mark;
    logic [PN_W-1:0]      ent_frame;
    logic                 ent_mark;
    logic                 unmap_ok;
    logic                 full;
    logic                 hit;
    logic [BIT_W-1:0]     zero_bit;
    logic [PN_W-1:0]      pt_rsel;
    logic [PAGE_AW-1:0]   page_idx;
    logic [WORD_AW-1:0]   bm_raddr;
    logic                 pt_we;
    logic [PAGE_AW-1:0]   pt_waddr;
    logic [ENT_W-1:0]     pt_wdata;
    logic                 bm_we;
    logic [WORD_AW-1:0]   bm_waddr;
    logic [WORD_BITS-1:0] bm_wdata;
    logic                 map_user;
    t_out                 res;

    assign page_ok   = {1'b0, r_req.page_number} < NPAGES_L;
    assign vpage     = r_req.vaddr[VA_W-1:OFS_W];
    assign vp_ok     = {1'b0, vpage} < NPAGES_L;
    assign map_frame = (r_req.action == ACT_IDENT) ? r_req.page_number : r_req.frame_number;
    assign map_ok    = page_ok && ({1'b0, map_frame} < MFRAMES_L);
    assign map_mark  = {1'b0, map_frame} < MARK_L;
    assign map_user  = (r_req.action == ACT_IDENT) ? 1'b1 : r_req.user_access;
    assign ent_frame = r_pt_q[ENT_W-1:ENT_FR_LSB];
    assign ent_mark  = {1'b0, ent_frame} < MARK_L;
    assign unmap_ok  = page_ok && r_pt_q[ENT_PRESENT];
    assign full      = &r_bm_q;
    assign hit       = r_chk_v && !full;
    assign zero_bit  = lowest_zero(r_bm_q);
    assign pt_rsel   = (r_req.action == ACT_XLATE) ? vpage : r_req.page_number;
    assign page_idx  = r_req.page_number[PAGE_AW-1:0];

    always_comb begin
        if (i_cmd.scan) begin
            bm_raddr = r_scan;
        end else if (i_cmd.unmap_rd) begin
            bm_raddr = ent_frame[BIT_W+WORD_AW-1:BIT_W];
        end else begin
            bm_raddr = map_frame[BIT_W+WORD_AW-1:BIT_W];
        end
    end

    always_comb begin
        pt_we    = 1'b0;
        pt_waddr = page_idx;
        pt_wdata = '0;
        bm_we    = 1'b0;
        bm_waddr = map_frame[BIT_W+WORD_AW-1:BIT_W];
        bm_wdata = r_bm_q | (WORD_BITS'(1) << map_frame[BIT_W-1:0]);
        if (i_cmd.clr) begin
            pt_we    = 1'b1;
            pt_waddr = r_clr;
            bm_we    = {1'b0, r_clr} < NWORDS_C;
            bm_waddr = r_clr[WORD_AW-1:0];
            bm_wdata = '0;
        end else if (i_cmd.map_wr) begin
            pt_we    = map_ok;
            pt_wdata = {map_frame, map_user, 2'b11};
            bm_we    = map_ok && map_mark;
        end else if (i_cmd.alloc_wr) begin
            pt_we    = 1'b1;
            pt_wdata = {r_found, r_req.user_access, 2'b11};
            bm_we    = 1'b1;
            bm_waddr = r_found[BIT_W+WORD_AW-1:BIT_W];
            bm_wdata = r_hit_word;
        end else if (i_cmd.unmap_wr) begin
            pt_we    = unmap_ok;
            bm_we    = unmap_ok && ent_mark;
            bm_waddr = ent_frame[BIT_W+WORD_AW-1:BIT_W];
            bm_wdata = r_bm_q & ~(WORD_BITS'(1) << ent_frame[BIT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        if (i_cmd.rd) begin
            r_pt_q <= pt_mem[pt_rsel[PAGE_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (i_cmd.rd || i_cmd.scan || i_cmd.unmap_rd) begin
            r_bm_q <= bm_mem[bm_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_chk_v <= 1'b0;
            r_fail  <= 1'b0;
            r_alloc <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.accept) begin
                r_chk_v <= 1'b0;
                r_fail  <= 1'b0;
                r_alloc <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_chk_v <= 1'b1;
            end
            if (i_cmd.fail) begin
                r_fail <= 1'b1;
            end
            if (i_cmd.alloc_wr) begin
                r_alloc <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req  <= i_in_data;
            r_scan <= '0;
        end
        if (i_cmd.scan) begin
            r_chk <= r_scan;
            if (r_scan != LAST_W) begin
                r_scan <= r_scan + 1'b1;
            end
            if (hit) begin
                r_found    <= PN_W'({r_chk, zero_bit});
                r_hit_word <= r_bm_q | (WORD_BITS'(1) << zero_bit);
            end
        end
        if (i_cmd.out_ld) begin
            o_out_data <= res;
        end
    end

    always_comb begin
        res           = '0;
        res.status    = r_fail;
        res.frame_out = r_alloc ? r_found : '0;
        if (r_req.action == ACT_XLATE) begin
            res.phys_addr = {(vp_ok ? ent_frame : PN_W'(0)), r_req.vaddr[OFS_W-1:0]};
        end
        res.present = (r_req.action == ACT_PRES) && page_ok && r_pt_q[ENT_PRESENT];
    end

    assign o_sts.action   = r_req.action;
    assign o_sts.page_ok  = page_ok;
    assign o_sts.hit      = hit;
    assign o_sts.scan_end = r_chk_v && full && (r_chk == LAST_W);
    assign o_sts.clr_done = r_clr == LAST_P;

endmodule

`default_nettype wire

FILE: sv/pmfb_ctrl.sv
`default_nettype none

module pmfb_ctrl import pmfb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    output logic o_out_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_READ     = 4'd2;
    localparam logic [3:0] S_MAP_WR   = 4'd3;
    localparam logic [3:0] S_SCAN     = 4'd4;
    localparam logic [3:0] S_ALLOC_WR = 4'd5;
    localparam logic [3:0] S_UNMAP_RD = 4'd6;
    localparam logic [3:0] S_UNMAP_WR = 4'd7;
    localparam logic [3:0] S_FINISH   = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                if (i_sts.action inside {ACT_IDENT, ACT_MAPAT}) begin
                    n_state = S_MAP_WR;
                end else if (i_sts.action == ACT_ALLOC) begin
                    n_state = i_sts.page_ok ? S_SCAN : S_FINISH;
                end else if (i_sts.action == ACT_UNMAP) begin
                    n_state = S_UNMAP_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_MAP_WR: begin
                o_cmd.map_wr = 1'b1;
                n_state      = S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit) begin
                    n_state = S_ALLOC_WR;
                end else if (i_sts.scan_end) begin
                    o_cmd.fail = 1'b1;
                    n_state    = S_FINISH;
                end
            end
            S_ALLOC_WR: begin
                o_cmd.alloc_wr = 1'b1;
                n_state        = S_FINISH;
            end
            S_UNMAP_RD: begin
                o_cmd.unmap_rd = 1'b1;
                n_state        = S_UNMAP_WR;
            end
            S_UNMAP_WR: begin
                o_cmd.unmap_wr = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.out_ld = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_ld) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.out_ld)
        else $error("result beat overwritten while stalled");

    a_hit_allocates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && i_sts.hit) |=> (r_state == S_ALLOC_WR))
        else $error("scan hit did not lead to allocation");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.out_ld))
        else $error("output valid without a result load");

    a_clear_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (o_in_stall && !o_cmd.accept))
        else $error("input taken during clearing pass");

endmodule

`default_nettype wire
